@@ design/hbf_pkg.sv @@
// Shared types, constants and arithmetic helpers for the harmonic bond force block.
`default_nettype none
package hbf_pkg;

    localparam int unsigned ATOM_COUNT = 4096;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned Q_DEPTH    = 2;
    localparam int unsigned MUL_STEPS  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF_Z = 3'd5;

    // virial terms: force axis and displacement axis per accumulator
    localparam logic [1:0] VIR_F_SEL [6] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] VIR_D_SEL [6] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};

    typedef struct packed {
        logic [11:0]        atom_a;
        logic [11:0]        atom_b;
        logic signed [31:0] pos_ax;
        logic signed [31:0] pos_ay;
        logic signed [31:0] pos_az;
        logic signed [31:0] pos_bx;
        logic signed [31:0] pos_by;
        logic signed [31:0] pos_bz;
        logic [30:0]        eq_length;
        logic [30:0]        spring_const;
        logic               last_bond;
    } bond_in_t;

    typedef struct packed {
        logic [11:0]        out_atom_a;
        logic [11:0]        out_atom_b;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [47:0] energy_total;
        logic signed [47:0] vir_xx;
        logic signed [47:0] vir_yx;
        logic signed [47:0] vir_yy;
        logic signed [47:0] vir_zx;
        logic signed [47:0] vir_zy;
        logic signed [47:0] vir_zz;
    } result_t;

    // classified bond between front and back
    typedef struct packed {
        logic [11:0]        atom_a;
        logic [11:0]        atom_b;
        logic               ok;
        logic               last;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [30:0]        k;
        logic [30:0]        r0;
    } job_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        mag64 = x[63] ? 64'(-x) : 64'(x);
    endfunction

    // product / 2^16, toward zero, saturated to 32 or 48 bits signed
    function automatic logic signed [47:0] q16_sat(input logic [127:0] p, input logic neg,
                                                   input logic is32);
        logic [63:0] slo;
        logic [63:0] lim;
        logic [63:0] v;
        logic [63:0] nv;
        slo = p[79:16];
        lim = is32 ? (64'h8000_0000 - {63'b0, ~neg}) : (64'h8000_0000_0000 - {63'b0, ~neg});
        v = ((|p[127:80]) || (slo > lim)) ? lim : slo;
        nv = 64'd0 - v;
        q16_sat = neg ? $signed(nv[47:0]) : $signed(v[47:0]);
    endfunction

    function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s[48] != s[47])
            sat_add48 = s[48] ? $signed(48'h8000_0000_0000) : $signed(48'h7FFF_FFFF_FFFF);
        else
            sat_add48 = s[47:0];
    endfunction

endpackage
`default_nettype wire

@@ design/hbf_front.sv @@
// Front end: takes bond words, checks indices, forms and folds the displacement.
`default_nettype none
module hbf_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire hbf_pkg::bond_in_t            bond,
    input  wire logic                         cfg_en,
    input  wire logic [hbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hbf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                              q_wr,
    output hbf_pkg::job_t                     q_din,
    input  wire logic                         q_full
);

    logic [30:0] len_reg [3];
    logic [30:0] half_reg [3];

    logic               s_vld_reg;
    logic [11:0]        s_a_reg;
    logic [11:0]        s_b_reg;
    logic               s_ok_reg;
    logic               s_last_reg;
    logic [30:0]        s_k_reg;
    logic [30:0]        s_r0_reg;
    logic signed [32:0] s_d_reg [3];

    logic accept;
    logic ok;

    function automatic logic signed [31:0] fold(input logic signed [32:0] d,
                                                input logic [30:0] len,
                                                input logic [30:0] half);
        logic signed [33:0] dw;
        logic signed [33:0] h;
        logic signed [33:0] l;
        logic signed [33:0] t;
        dw = 34'(d);
        h  = $signed({3'b0, half});
        l  = $signed({3'b0, len});
        if (dw > h)
            t = dw - l;
        else if (dw < -h)
            t = dw + l;
        else
            t = dw;
        if (t > $signed(34'h0_7FFF_FFFF))
            fold = $signed(32'h7FFF_FFFF);
        else if (t < $signed(34'h3_8000_0000))
            fold = $signed(32'h8000_0000);
        else
            fold = t[31:0];
    endfunction

    assign full   = s_vld_reg && q_full;
    assign accept = push && !full;
    assign q_wr   = s_vld_reg && !q_full;
    assign ok     = ({5'b0, bond.atom_a} < 17'(hbf_pkg::ATOM_COUNT))
                 && ({5'b0, bond.atom_b} < 17'(hbf_pkg::ATOM_COUNT));

    always_comb
    begin
        q_din.atom_a = s_a_reg;
        q_din.atom_b = s_b_reg;
        q_din.ok     = s_ok_reg;
        q_din.last   = s_last_reg;
        q_din.dx     = fold(s_d_reg[0], len_reg[0], half_reg[0]);
        q_din.dy     = fold(s_d_reg[1], len_reg[1], half_reg[1]);
        q_din.dz     = fold(s_d_reg[2], len_reg[2], half_reg[2]);
        q_din.k      = s_k_reg;
        q_din.r0     = s_r0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                len_reg[i]  <= '0;
                half_reg[i] <= '0;
            end
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                hbf_pkg::CFG_BOX_LEN_X:  len_reg[0]  <= cfg_data;
                hbf_pkg::CFG_BOX_LEN_Y:  len_reg[1]  <= cfg_data;
                hbf_pkg::CFG_BOX_LEN_Z:  len_reg[2]  <= cfg_data;
                hbf_pkg::CFG_BOX_HALF_X: half_reg[0] <= cfg_data;
                hbf_pkg::CFG_BOX_HALF_Y: half_reg[1] <= cfg_data;
                hbf_pkg::CFG_BOX_HALF_Z: half_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= 1'b0;
        else if (accept)
            s_vld_reg <= 1'b1;
        else if (q_wr)
            s_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_a_reg    <= bond.atom_a;
            s_b_reg    <= bond.atom_b;
            s_ok_reg   <= ok;
            s_last_reg <= bond.last_bond;
            s_k_reg    <= bond.spring_const;
            s_r0_reg   <= bond.eq_length;
            s_d_reg[0] <= 33'(bond.pos_bx) - 33'(bond.pos_ax);
            s_d_reg[1] <= 33'(bond.pos_by) - 33'(bond.pos_ay);
            s_d_reg[2] <= 33'(bond.pos_bz) - 33'(bond.pos_az);
        end
    end

endmodule
`default_nettype wire

@@ design/hbf_fifo.sv @@
// Short queue of classified bonds between front and back.
`default_nettype none
module hbf_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire hbf_pkg::job_t din,
    output logic               full,
    input  wire logic          rd,
    output hbf_pkg::job_t      dout,
    output logic               empty
);

    localparam int unsigned PW = $clog2(hbf_pkg::Q_DEPTH);
    localparam int unsigned CW = $clog2(hbf_pkg::Q_DEPTH + 1);

    hbf_pkg::job_t   ent_reg [hbf_pkg::Q_DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [CW-1:0]   cnt_reg;

    assign full  = (cnt_reg == CW'(hbf_pkg::Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && !full)
                wp_reg <= (wp_reg == PW'(hbf_pkg::Q_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd && !empty)
                rp_reg <= (rp_reg == PW'(hbf_pkg::Q_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + CW'(wr && !full) - CW'(rd && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            ent_reg[wp_reg] <= din;
    end

endmodule
`default_nettype wire

@@ design/hbf_mul.sv @@
// Shared 64x64 multiplier: one 32x32 partial product per cycle, accumulated.
`default_nettype none
module hbf_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hbf_pkg::mul_req_t req,
    output hbf_pkg::mul_rsp_t      rsp
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_vld_reg;
    logic [127:0] acc_reg;
    logic         done_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  prod32;
    logic [127:0] pp_shifted;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign prod32 = a_half * b_half;

    always_comb
    begin
        unique case (pp_sh_reg)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {pp_reg, 64'b0};
            default: pp_shifted = '0;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= '0;
            b_reg      <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            pp_reg     <= '0;
            pp_sh_reg  <= '0;
            pp_vld_reg <= 1'b0;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                a_reg      <= req.a;
                b_reg      <= req.b;
                cnt_reg    <= '0;
                busy_reg   <= 1'b1;
                acc_reg    <= '0;
                pp_vld_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (pp_vld_reg)
                    acc_reg <= acc_reg + pp_shifted;
                if (cnt_reg != 3'(hbf_pkg::MUL_STEPS))
                begin
                    pp_reg     <= prod32;
                    pp_sh_reg  <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    pp_vld_reg <= 1'b1;
                    cnt_reg    <= cnt_reg + 3'd1;
                end
                else
                begin
                    pp_vld_reg <= 1'b0;
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ design/hbf_back.sv @@
// Back end: sequencer for distance, force, energy and virial, plus result register.
`default_nettype none
module hbf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire hbf_pkg::job_t     q_dout,
    output logic                   q_rd,
    output hbf_pkg::mul_req_t      mul_req,
    input  wire hbf_pkg::mul_rsp_t mul_rsp,
    output logic                   empty,
    input  wire logic              pop,
    output hbf_pkg::result_t       result
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_SQRT = 4'd2;
    localparam logic [3:0] ST_KR   = 4'd3;
    localparam logic [3:0] ST_EN   = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_FRC  = 4'd6;
    localparam logic [3:0] ST_VIR  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]         st_reg;
    logic [2:0]         idx_reg;
    logic               wait_reg;
    hbf_pkg::job_t      job_reg;
    logic [63:0]        d2_reg;
    logic [63:0]        sv_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        r_reg;
    logic signed [47:0] kr_reg;
    logic [32:0]        rem_reg;
    logic [15:0]        q_reg;
    logic [4:0]         dcnt_reg;
    logic signed [17:0] u_reg [3];
    logic signed [31:0] f_reg [3];
    logic signed [47:0] en_acc_reg;
    logic signed [47:0] vir_acc_reg [6];
    logic               out_vld_reg;
    hbf_pkg::result_t   out_reg;

    logic signed [31:0] d_sel;
    logic signed [31:0] d_nxt;
    logic [63:0]        d_sel_mag;
    logic [63:0]        d_nxt_mag;
    logic signed [32:0] rr;
    logic [63:0]        rr_mag;
    logic signed [49:0] fr;
    logic signed [31:0] vf;
    logic signed [31:0] vd;
    logic               mul_state;
    logic               is32;
    logic               neg;
    logic signed [47:0] term;
    logic [63:0]        sq_sum;
    logic [63:0]        try_v;
    logic [63:0]        res_next;
    logic [63:0]        sv_next;
    logic               ge;
    logic [32:0]        rem_sub;
    logic [16:0]        quo;

    function automatic logic signed [31:0] axis(input hbf_pkg::job_t j, input logic [1:0] s);
        case (s)
            2'd0:    axis = j.dx;
            2'd1:    axis = j.dy;
            default: axis = j.dz;
        endcase
    endfunction

    assign d_sel     = axis(job_reg, idx_reg[1:0]);
    assign d_nxt     = axis(job_reg, idx_reg[1:0] + 2'd1);
    assign d_sel_mag = hbf_pkg::mag64(64'(d_sel));
    assign d_nxt_mag = hbf_pkg::mag64(64'(d_nxt));
    assign rr        = $signed({1'b0, r_reg}) - $signed({2'b0, job_reg.r0});
    assign rr_mag    = hbf_pkg::mag64(64'(rr));
    assign fr        = -(50'(kr_reg) <<< 1);
    assign vf        = f_reg[hbf_pkg::VIR_F_SEL[idx_reg]];
    assign vd        = axis(job_reg, hbf_pkg::VIR_D_SEL[idx_reg]);

    assign mul_state = (st_reg == ST_SQ) || (st_reg == ST_KR) || (st_reg == ST_EN)
                    || (st_reg == ST_FRC) || (st_reg == ST_VIR);

    always_comb
    begin
        mul_req.start = mul_state && !wait_reg;
        mul_req.a     = '0;
        mul_req.b     = '0;
        neg           = 1'b0;
        is32          = 1'b0;
        unique case (st_reg)
            ST_SQ:
            begin
                mul_req.a = d_sel_mag;
                mul_req.b = d_sel_mag;
            end
            ST_KR:
            begin
                mul_req.a = {33'b0, job_reg.k};
                mul_req.b = rr_mag;
                neg       = rr[32];
            end
            ST_EN:
            begin
                mul_req.a = hbf_pkg::mag64(64'(kr_reg));
                mul_req.b = rr_mag;
                neg       = kr_reg[47] ^ rr[32];
            end
            ST_FRC:
            begin
                mul_req.a = hbf_pkg::mag64(64'(fr));
                mul_req.b = hbf_pkg::mag64(64'(u_reg[idx_reg[1:0]]));
                neg       = fr[49] ^ u_reg[idx_reg[1:0]][17];
                is32      = 1'b1;
            end
            ST_VIR:
            begin
                mul_req.a = hbf_pkg::mag64(64'(vf));
                mul_req.b = hbf_pkg::mag64(64'(vd));
                neg       = vf[31] ^ vd[31];
            end
            default: ;
        endcase
    end

    assign term   = hbf_pkg::q16_sat(mul_rsp.prod, neg, is32);
    assign sq_sum = d2_reg + mul_rsp.prod[63:0];

    // one bit of the integer square root
    assign try_v = res_reg + bit_reg;
    always_comb
    begin
        if (sv_reg >= try_v)
        begin
            sv_next  = sv_reg - try_v;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            sv_next  = sv_reg;
            res_next = res_reg >> 1;
        end
    end

    // one quotient bit of |d| * 2^16 / r
    assign ge      = (rem_reg >= {1'b0, r_reg});
    assign rem_sub = ge ? (rem_reg - {1'b0, r_reg}) : rem_reg;
    assign quo     = {q_reg, ge};

    assign q_rd  = (st_reg == ST_IDLE) && !q_empty;
    assign empty = !out_vld_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            idx_reg     <= '0;
            wait_reg    <= 1'b0;
            job_reg     <= '0;
            d2_reg      <= '0;
            sv_reg      <= '0;
            res_reg     <= '0;
            bit_reg     <= '0;
            r_reg       <= '0;
            kr_reg      <= '0;
            rem_reg     <= '0;
            q_reg       <= '0;
            dcnt_reg    <= '0;
            en_acc_reg  <= '0;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= '0;
                f_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++)
                vir_acc_reg[i] <= '0;
        end
        else
        begin
            if (pop && out_vld_reg)
                out_vld_reg <= 1'b0;

            if (mul_req.start)
                wait_reg <= 1'b1;
            else if (mul_rsp.done)
                wait_reg <= 1'b0;

            unique case (st_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg <= q_dout;
                        d2_reg  <= '0;
                        idx_reg <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            u_reg[i] <= '0;
                            f_reg[i] <= '0;
                        end
                        st_reg <= q_dout.ok ? ST_SQ : ST_OUT;
                    end
                end
                ST_SQ:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        d2_reg <= sq_sum;
                        if (idx_reg == 3'd2)
                        begin
                            idx_reg <= '0;
                            sv_reg  <= sq_sum;
                            res_reg <= '0;
                            bit_reg <= 64'h4000_0000_0000_0000;
                            st_reg  <= ST_SQRT;
                        end
                        else
                            idx_reg <= idx_reg + 3'd1;
                    end
                end
                ST_SQRT:
                begin
                    sv_reg  <= sv_next;
                    res_reg <= res_next;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        r_reg  <= res_next[31:0];
                        st_reg <= ST_KR;
                    end
                end
                ST_KR:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        kr_reg <= term;
                        st_reg <= ST_EN;
                    end
                end
                ST_EN:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        en_acc_reg <= hbf_pkg::sat_add48(en_acc_reg, term);
                        rem_reg    <= d_sel_mag[32:0];
                        dcnt_reg   <= '0;
                        // zero length: no direction, so force and virial stay zero
                        st_reg     <= (r_reg == '0) ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    q_reg    <= quo[15:0];
                    rem_reg  <= {rem_sub[31:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd16)
                    begin
                        u_reg[idx_reg[1:0]] <= d_sel[31] ? -$signed({1'b0, quo})
                                                         : $signed({1'b0, quo});
                        dcnt_reg <= '0;
                        rem_reg  <= d_nxt_mag[32:0];
                        if (idx_reg == 3'd2)
                        begin
                            idx_reg <= '0;
                            st_reg  <= ST_FRC;
                        end
                        else
                            idx_reg <= idx_reg + 3'd1;
                    end
                end
                ST_FRC:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        f_reg[idx_reg[1:0]] <= term[31:0];
                        if (idx_reg == 3'd2)
                        begin
                            idx_reg <= '0;
                            st_reg  <= ST_VIR;
                        end
                        else
                            idx_reg <= idx_reg + 3'd1;
                    end
                end
                ST_VIR:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        vir_acc_reg[idx_reg] <= hbf_pkg::sat_add48(vir_acc_reg[idx_reg], term);
                        if (idx_reg == 3'd5)
                        begin
                            idx_reg <= '0;
                            st_reg  <= ST_OUT;
                        end
                        else
                            idx_reg <= idx_reg + 3'd1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_vld_reg)
                    begin
                        out_reg.out_atom_a   <= job_reg.atom_a;
                        out_reg.out_atom_b   <= job_reg.atom_b;
                        out_reg.force_x      <= f_reg[0];
                        out_reg.force_y      <= f_reg[1];
                        out_reg.force_z      <= f_reg[2];
                        out_reg.energy_total <= en_acc_reg;
                        out_reg.vir_xx       <= vir_acc_reg[0];
                        out_reg.vir_yx       <= vir_acc_reg[1];
                        out_reg.vir_yy       <= vir_acc_reg[2];
                        out_reg.vir_zx       <= vir_acc_reg[3];
                        out_reg.vir_zy       <= vir_acc_reg[4];
                        out_reg.vir_zz       <= vir_acc_reg[5];
                        out_vld_reg          <= 1'b1;
                        if (job_reg.last)
                        begin
                            en_acc_reg <= '0;
                            for (int i = 0; i < 6; i++)
                                vir_acc_reg[i] <= '0;
                        end
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> wait_reg)
        else $error("multiplier finished with no request outstanding");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OUT && !out_vld_reg) |=> (out_vld_reg && st_reg == ST_IDLE))
        else $error("result not loaded from output state");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OUT && !out_vld_reg && job_reg.last) |=>
        (en_acc_reg == 48'sd0 && vir_acc_reg[0] == 48'sd0 && vir_acc_reg[5] == 48'sd0))
        else $error("sums not cleared after last bond");

endmodule
`default_nettype wire

@@ design/harmonic_bond_force_top.sv @@
// Harmonic bond force block: front end, bond queue, shared multiplier and back end.
// Each bond word gives one result word: the two atom indices, the bond force on atom b
// (negate it for atom a) and the running energy and virial sums, which clear after a word
// marked last_bond. Positions and box registers are Q16.16; sums are Q32.16 and saturate.
// A bond with an index at or above ATOM_COUNT gives zero force and adds nothing to the sums.
// In the back end a bond takes fourteen products on the shared multiplier, a 32-step square
// root, three 17-step divisions, taking the bond and loading the result; a bad-index bond
// skips from taking to loading. The front end and a two-word queue take new bonds while
// the back end works, and the result register holds a finished word until it is popped,
// which stalls the back end. Box registers are written through cfg_en / cfg_index / cfg_data;
// the user writes them only while no bond is in flight; the block does not enforce it.
`default_nettype none
module harmonic_bond_force_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire hbf_pkg::bond_in_t              bond,
    input  wire logic                           cfg_en,
    input  wire logic [hbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hbf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                empty,
    input  wire logic                           pop,
    output hbf_pkg::result_t                    result
);

    logic              q_wr;
    logic              q_full;
    logic              q_rd;
    logic              q_empty;
    hbf_pkg::job_t     q_din;
    hbf_pkg::job_t     q_dout;
    hbf_pkg::mul_req_t mul_req;
    hbf_pkg::mul_rsp_t mul_rsp;

    hbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .bond      (bond),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_wr      (q_wr),
        .q_din     (q_din),
        .q_full    (q_full)
    );

    hbf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .din   (q_din),
        .full  (q_full),
        .rd    (q_rd),
        .dout  (q_dout),
        .empty (q_empty)
    );

    hbf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    hbf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_dout  (q_dout),
        .q_rd    (q_rd),
        .mul_req (mul_req),
        .mul_rsp (mul_rsp),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire
